// ----- design/msort_pkg.sv -----
// msort_pkg: types and constants shared by the merge sorter modules.
// No dependencies.
package msort_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned DATA_W        = 32;

  // stream-side control of the top level
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_REQ,
    ST_WAIT
  } top_state_e;

  // merge sequencer in the core
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_SETUP,
    CORE_MERGE
  } core_state_e;

  // requests from the stream side to the core
  typedef struct packed {
    logic start;    // run closed, sort the first n entries of bank 0
    logic load_we;  // store one incoming element in bank 0
  } core_req_t;

endpackage

// ----- design/msort_core.sv -----
// msort_core: the two element banks and the bottom-up merge sequencer.
// One signed compare per cycle, apart from the setup state that opens each merge segment,
// merges from the source bank into the other one. Depends on msort_pkg.
module msort_core #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF,
  localparam int unsigned AW = $clog2(MAX_ITEMS),
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msort_pkg::core_req_t           req_i,
  input  logic [CW-1:0]                  n_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [msort_pkg::DATA_W-1:0]   wr_data_i,
  input  logic [AW-1:0]                  rd_addr_i,
  output logic [msort_pkg::DATA_W-1:0]   rd_data_o,
  output logic                           done_o
);
  import msort_pkg::*;

  localparam int unsigned SW = CW + 2;

  core_state_e state_q, state_d;

  logic          sel_q, sel_d;     // source bank of the running pass
  logic          done_q, done_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] mid_q, mid_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_q, k_d;

  logic [DATA_W-1:0] bank0 [MAX_ITEMS];
  logic [DATA_W-1:0] bank1 [MAX_ITEMS];
  logic [DATA_W-1:0] b0_a_q, b0_b_q, b1_a_q, b1_b_q;

  logic [AW-1:0]     addr_a, addr_b;
  logic              we0, we1;
  logic [AW-1:0]     waddr0;
  logic [DATA_W-1:0] wdata0;

  logic [DATA_W-1:0] src_a, src_b, merge_val;
  logic              take_a;

  // segment bounds for the next segment to open
  logic [CW-1:0] n_sel, base_lo, base_w;
  logic [SW-1:0] sum_mid, sum_hi, next_lo, w_dbl;
  logic [CW-1:0] base_mid, base_hi;
  logic          seg_end, more_segs, more_passes;

  assign src_a = sel_q ? b1_a_q : b0_a_q;
  assign src_b = sel_q ? b1_b_q : b0_b_q;

  // ties go to the left run, which keeps the sort stable
  assign take_a = (i_q < mid_q) &&
                  ((j_q >= hi_q) || ($signed(src_a) <= $signed(src_b)));
  assign merge_val = take_a ? src_a : src_b;

  assign seg_end     = ((k_q + CW'(1)) == hi_q);
  assign next_lo     = SW'(lo_q) + SW'({w_q, 1'b0});
  assign w_dbl       = SW'({w_q, 1'b0});
  assign more_segs   = (next_lo < SW'(n_q));
  assign more_passes = (w_dbl < SW'(n_q));

  always_comb begin
    n_sel   = (state_q == CORE_IDLE) ? n_i : n_q;
    base_lo = '0;
    base_w  = CW'(1);
    if (state_q == CORE_MERGE) begin
      if (more_segs) begin
        base_lo = next_lo[CW-1:0];
        base_w  = w_q;
      end else begin
        base_w  = w_dbl[CW-1:0];
      end
    end
    sum_mid  = SW'(base_lo) + SW'(base_w);
    sum_hi   = SW'(base_lo) + SW'({base_w, 1'b0});
    base_mid = (sum_mid < SW'(n_sel)) ? sum_mid[CW-1:0] : n_sel;
    base_hi  = (sum_hi < SW'(n_sel)) ? sum_hi[CW-1:0] : n_sel;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CORE_IDLE: begin
        if (req_i.start && (n_i > CW'(1))) state_d = CORE_SETUP;
      end
      CORE_SETUP: state_d = CORE_MERGE;
      CORE_MERGE: begin
        if (seg_end) begin
          if (more_segs || more_passes) state_d = CORE_SETUP;
          else state_d = CORE_IDLE;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  // sequencer registers and memory control
  always_comb begin
    sel_d  = sel_q;
    done_d = 1'b0;
    n_d    = n_q;
    w_d    = w_q;
    lo_d   = lo_q;
    mid_d  = mid_q;
    hi_d   = hi_q;
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    addr_a = rd_addr_i;
    addr_b = rd_addr_i;
    we0    = 1'b0;
    we1    = 1'b0;
    waddr0 = wr_addr_i;
    wdata0 = wr_data_i;
    unique case (state_q)
      CORE_IDLE: begin
        we0 = req_i.load_we;
        if (req_i.start) begin
          sel_d = 1'b0;
          n_d   = n_i;
          w_d   = CW'(1);
          lo_d  = '0;
          mid_d = base_mid;
          hi_d  = base_hi;
          i_d   = '0;
          j_d   = base_mid;
          k_d   = '0;
          done_d = (n_i <= CW'(1));
        end
      end
      CORE_SETUP: begin
        addr_a = i_q[AW-1:0];
        addr_b = j_q[AW-1:0];
      end
      CORE_MERGE: begin
        we0    = sel_q;
        we1    = !sel_q;
        waddr0 = k_q[AW-1:0];
        wdata0 = merge_val;
        i_d    = i_q + CW'(take_a);
        j_d    = j_q + CW'(!take_a);
        k_d    = k_q + CW'(1);
        // next pair is fetched right away so one element lands per cycle
        addr_a = i_d[AW-1:0];
        addr_b = j_d[AW-1:0];
        if (seg_end) begin
          if (!more_segs) sel_d = !sel_q;
          if (more_segs || more_passes) begin
            w_d   = base_w;
            lo_d  = base_lo;
            mid_d = base_mid;
            hi_d  = base_hi;
            i_d   = base_lo;
            j_d   = base_mid;
            k_d   = base_lo;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      sel_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    k_q   <= k_d;
  end

  always_ff @(posedge clk_i) begin
    if (we0) bank0[waddr0] <= wdata0;
    b0_a_q <= bank0[addr_a];
    b0_b_q <= bank0[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (we1) bank1[k_q[AW-1:0]] <= merge_val;
    b1_a_q <= bank1[addr_a];
    b1_b_q <= bank1[addr_b];
  end

  // after the last pass sel_q names the bank holding the sorted run
  assign rd_data_o = src_a;
  assign done_o    = done_q;

endmodule

// ----- design/merge_sorter.sv -----
// merge_sorter: collects a run of signed values, merge sorts it, streams it out.
// Depends on msort_pkg and msort_core.
//
//  channel   dir  beat fields
//  s_axis    in   tdata = value, tlast = last
//  m_axis    out  tdata = sorted_value, tlast = end_of_run, tuser = overflow
//
// Load: one cycle per beat while collecting. After the closing beat the core
// runs ceil(log2(n)) passes; in each pass a setup state fetches the first pair
// of every merge segment, then one compare in the core per cycle merges it.
// Drain: each sorted beat takes a bank read, then an output register load, and
// the next bank read waits until that load is done. No clearing pass after
// reset. s_axis_tready is low from the closing beat until the final sorted
// beat sits in the output register; m_axis stalls simply hold the drain.
module merge_sorter #(
  parameter int unsigned MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [msort_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] value
  input  logic                           s_axis_tlast,  // last
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [msort_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] sorted_value
  output logic                           m_axis_tlast,  // end_of_run
  output logic                           m_axis_tuser   // [0] overflow
);
  import msort_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  top_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] run_n_q, run_n_d;
  logic          run_ovf_q, run_ovf_d;
  logic [CW-1:0] dk_q, dk_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic              out_last_q, out_user_q;

  logic              in_beat, full, out_free, out_load, drain_end;
  logic [CW-1:0]     cnt_inc;
  core_req_t         core_req;
  logic [DATA_W-1:0] rd_data;
  logic              core_done;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign full      = (cnt_q == CW'(MAX_ITEMS));
  assign cnt_inc   = full ? cnt_q : cnt_q + CW'(1);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign drain_end = ((dk_q + CW'(1)) == run_n_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_beat && s_axis_tlast) state_d = ST_SORT;
      ST_SORT: if (core_done) state_d = ST_REQ;
      ST_REQ:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (out_free) state_d = drain_end ? ST_LOAD : ST_REQ;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready    = (state_q == ST_LOAD);
    core_req.start   = 1'b0;
    core_req.load_we = 1'b0;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    run_n_d   = run_n_q;
    run_ovf_d = run_ovf_q;
    dk_d      = dk_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          core_req.load_we = !full;
          cnt_d = cnt_inc;
          ovf_d = ovf_q | full;
          if (s_axis_tlast) begin
            core_req.start = 1'b1;
            run_n_d   = cnt_inc;
            run_ovf_d = ovf_q | full;
            cnt_d     = '0;
            ovf_d     = 1'b0;
          end
        end
      end
      ST_SORT: dk_d = '0;
      ST_REQ:  ;
      ST_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          dk_d     = dk_q + CW'(1);
        end
      end
      default: ;
    endcase
    out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_n_q   <= run_n_d;
    run_ovf_q <= run_ovf_d;
    dk_q      <= dk_d;
    if (out_load) begin
      out_data_q <= rd_data;
      out_last_q <= drain_end;
      out_user_q <= run_ovf_q;
    end
  end

  msort_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (core_req),
    .n_i       (run_n_d),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_addr_i (dk_q[AW-1:0]),
    .rd_data_o (rd_data),
    .done_o    (core_done)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- design/msort_checker.sv -----
// msort_checker: port-level checks of merge_sorter, bound to the top level.
// Depends on msort_pkg for the data width.
module msort_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tlast,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [msort_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast,
  input logic                         m_axis_tuser
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // closing beat starts the sort, input closes at once
  a_close_stops_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after closing beat");

  // input reopens only with the final sorted beat on the output
  a_reopen_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("input reopened before final sorted beat");

  // while collecting, only the final beat of the previous run can be pending
  a_open_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("non-final sorted beat pending while input open");

endmodule

bind merge_sorter msort_checker u_msort_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
